[rtl/core/skt_pkg.sv]
package skt_pkg;

    // Default sizing of the table
    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CLEAR  = 2'd3
    } skt_op_t;

    // Broadcast command from the sequencer to every cell
    typedef struct packed {
        logic cmp;  // compare stored key against the request key
        logic ins;  // open a slot and insert the request key
        logic del;  // close the slot of the first equal key
        logic clr;  // empty the cell
    } skt_cmd_t;

    // Status a cell shows to its neighbours and to the sequencer
    typedef struct packed {
        logic valid;  // cell holds a key
        logic lt;     // stored key is smaller than the request key
        logic eq;     // stored key equals the request key
    } skt_flags_t;

endpackage

[rtl/core/skt_cell.sv]
module skt_cell
    import skt_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  skt_cmd_t                    cmd,
    input  logic signed [KEY_WIDTH-1:0] req_key,
    input  skt_flags_t                  left_flags,
    input  logic signed [KEY_WIDTH-1:0] left_key,
    input  logic                        right_valid,
    input  logic signed [KEY_WIDTH-1:0] right_key,
    output skt_flags_t                  flags,
    output logic signed [KEY_WIDTH-1:0] entry_key
);

    logic                        valid_reg, valid_next;
    logic                        lt_reg, lt_next;
    logic                        eq_reg, eq_next;
    logic signed [KEY_WIDTH-1:0] key_reg, key_next;

    // Work out the next contents of the cell
    always_comb
    begin
        valid_next = valid_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        key_next   = key_reg;

        // Compare against the broadcast key
        if (cmd.cmp)
        begin
            lt_next = valid_reg && (key_reg < req_key);
            eq_next = valid_reg && (key_reg == req_key);
        end

        // Insert: keep smaller keys, take the new key at the boundary, shift the rest right
        if (cmd.ins && !lt_reg)
        begin
            key_next   = left_flags.lt ? req_key : left_key;
            valid_next = valid_reg | left_flags.valid;
        end

        // Delete: from the first not-smaller key onward, pull the right neighbour in
        if (cmd.del && !lt_reg)
        begin
            key_next   = right_key;
            valid_next = right_valid;
        end

        // Clear: drop the entry
        if (cmd.clr)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
        end
    end

    // Hold the stored key
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign flags.valid = valid_reg;
    assign flags.lt    = lt_reg;
    assign flags.eq    = eq_reg;
    assign entry_key   = key_reg;

endmodule

[rtl/core/sorted_key_table_core.sv]
// Channel   Handshake              Payload
// request   start, busy            opcode, key
// result    done (one-cycle pulse) ok, full_res, count
//
// A request is taken at a clock edge with start high and busy low.
// Each request is latched, then every cell compares its key against the request key (S_CMP),
// and then the row of cells shifts to insert or delete (S_APPLY).
// The result pulses on done in the cycle after the shift, when busy is already low again.
// Reset empties the table at once through the per-cell valid bits; no clearing pass is needed.
// The receiver cannot stall; done carries the result for exactly one cycle.
module sorted_key_table_core
    import skt_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int CNT_W     = $clog2(CAPACITY + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  opcode,
    input  logic signed [KEY_WIDTH-1:0] key,
    output logic                        done,
    output logic                        ok,
    output logic                        full_res,
    output logic [CNT_W-1:0]            count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } state_t;

    state_t                      state_reg, state_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic                        ok_reg, ok_next;
    logic                        full_reg, full_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    skt_op_t                     op_reg, op_next;
    logic signed [KEY_WIDTH-1:0] key_reg, key_next;

    skt_cmd_t                    cmd;
    skt_flags_t                  cell_flags [CAPACITY];
    logic signed [KEY_WIDTH-1:0] cell_key   [CAPACITY];
    skt_flags_t                  left_flags [CAPACITY];
    logic signed [KEY_WIDTH-1:0] left_key   [CAPACITY];
    logic                        right_valid[CAPACITY];
    logic signed [KEY_WIDTH-1:0] right_key  [CAPACITY];
    logic [CAPACITY-1:0]         hit_vec;
    logic [CAPACITY-1:0]         valid_vec;
    logic                        found;
    logic                        room;

    // Wire each cell to its neighbours; the ends see fixed boundary flags and the request key
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cells
        if (i == 0)
        begin : g_first
            assign left_flags[i] = '{valid: 1'b1, lt: 1'b1, eq: 1'b0};
            assign left_key[i]   = key_reg;
        end
        else
        begin : g_inner_left
            assign left_flags[i] = cell_flags[i-1];
            assign left_key[i]   = cell_key[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_valid[i] = 1'b0;
            assign right_key[i]   = key_reg;
        end
        else
        begin : g_inner_right
            assign right_valid[i] = cell_flags[i+1].valid;
            assign right_key[i]   = cell_key[i+1];
        end

        // First not-smaller entry that is equal to the request key
        assign hit_vec[i]   = cell_flags[i].eq & left_flags[i].lt;
        assign valid_vec[i] = cell_flags[i].valid;

        skt_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .req_key     (key_reg),
            .left_flags  (left_flags[i]),
            .left_key    (left_key[i]),
            .right_valid (right_valid[i]),
            .right_key   (right_key[i]),
            .flags       (cell_flags[i]),
            .entry_key   (cell_key[i])
        );
    end

    assign found = |hit_vec;
    assign room  = (count_reg < CNT_W'(CAPACITY));

    // Drive the broadcast command
    always_comb
    begin
        cmd.cmp = (state_reg == S_CMP);
        cmd.ins = (state_reg == S_APPLY) && (op_reg == OP_INSERT) && room;
        cmd.del = (state_reg == S_APPLY) && (op_reg == OP_DELETE) && found;
        cmd.clr = (state_reg == S_APPLY) && (op_reg == OP_CLEAR);
    end

    // Sequence a request and build its result
    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        ok_next    = ok_reg;
        full_next  = full_reg;
        count_next = count_reg;
        op_next    = op_reg;
        key_next   = key_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = skt_op_t'(opcode);
                    key_next   = key;
                    busy_next  = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        ok_next = room;
                        if (room)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    OP_DELETE:
                    begin
                        ok_next = found;
                        if (found)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    OP_SEARCH:
                    begin
                        ok_next = found;
                    end
                    OP_CLEAR:
                    begin
                        ok_next    = 1'b1;
                        count_next = '0;
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
                full_next  = (count_next == CNT_W'(CAPACITY));
                done_next  = 1'b1;
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, request and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
            full_reg  <= 1'b0;
            count_reg <= '0;
            op_reg    <= OP_INSERT;
            key_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            ok_reg    <= ok_next;
            full_reg  <= full_next;
            count_reg <= count_next;
            op_reg    <= op_next;
            key_reg   <= key_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign ok       = ok_reg;
    assign full_res = full_reg;
    assign count    = count_reg;

    // Occupied cells always form a prefix of the row
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + 1'b1) & valid_vec) == '0)
        else $error("occupied cells do not form a prefix");

    // Count tracks the number of occupied cells
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == count_reg)
        else $error("count differs from occupied cells");

    // Never more keys than cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    // At most one cell marks the first equal key
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> $onehot0(hit_vec))
        else $error("more than one delete or search hit");

    // A taken request holds busy through compare and apply, then gives its result on done with busy low
    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy ##1 busy ##1 (done && !busy))
        else $error("result not delivered on schedule");

endmodule

[tb/sv/tb_sorted_key_table_core.sv]
`timescale 1ns / 1ps

module tb_sorted_key_table_core;
    import skt_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int KW  = KEY_WIDTH_DEF;
    localparam int CW  = $clog2(CAP + 1);

    typedef logic signed [KW-1:0] key_t;

    localparam key_t KEY_MIN = {1'b1, {(KW-1){1'b0}}};
    localparam key_t KEY_MAX = {1'b0, {(KW-1){1'b1}}};

    localparam int RANDOM_REQS = 1750;
    localparam int POOL_SIZE   = 16;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        skt_op_t     op;
        key_t        key;
        int unsigned gap;
    } table_req_t;

    typedef struct packed {
        logic          ok;
        logic          full;
        logic [CW-1:0] count;
    } table_status_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic [1:0]    opcode = 2'd0;
    key_t          key = '0;
    logic          done;
    logic          ok;
    logic          full_res;
    logic [CW-1:0] count;

    // Requests waiting to be driven, and status words still to come back
    table_req_t    req_queue[$];
    table_status_t status_queue[$];

    // Own copy of the sorted table
    key_t sorted_keys[CAP];
    int   stored_count = 0;

    // Driver bookkeeping
    table_req_t  cur_req;
    logic        have_req = 1'b0;
    int unsigned hold_left = 0;
    int unsigned sent_count = 0;
    int unsigned taken_count = 0;

    // Stimulus shaping
    key_t key_pool[POOL_SIZE];
    logic calm = 1'b0;

    // Run statistics
    int n_insert = 0;
    int n_refused = 0;
    int n_del_hit = 0;
    int n_search_hit = 0;
    int n_clear = 0;
    int n_full = 0;
    int n_results = 0;
    int failures = 0;

    table_status_t got;
    table_status_t want;

    sorted_key_table_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .opcode   (opcode),
        .key      (key),
        .done     (done),
        .ok       (ok),
        .full_res (full_res),
        .count    (count)
    );

    always #10 clk = ~clk;

    // Apply one request to the local table and queue the status it should give
    function void update_sorted_keys(input skt_op_t op, input key_t k);
        int pos;
        int i;
        table_status_t st;
        pos = 0;
        while (pos < stored_count && sorted_keys[pos] < k)
            pos++;
        st.ok = 1'b0;
        case (op)
            OP_INSERT:
            begin
                n_insert++;
                if (stored_count < CAP)
                begin
                    for (i = stored_count; i > pos; i--)
                        sorted_keys[i] = sorted_keys[i-1];
                    sorted_keys[pos] = k;
                    stored_count++;
                    st.ok = 1'b1;
                end
                else
                    n_refused++;
            end
            OP_DELETE:
            begin
                if (pos < stored_count && sorted_keys[pos] == k)
                begin
                    for (i = pos; i + 1 < stored_count; i++)
                        sorted_keys[i] = sorted_keys[i+1];
                    stored_count--;
                    st.ok = 1'b1;
                    n_del_hit++;
                end
            end
            OP_SEARCH:
            begin
                if (pos < stored_count && sorted_keys[pos] == k)
                begin
                    st.ok = 1'b1;
                    n_search_hit++;
                end
            end
            default:
            begin
                stored_count = 0;
                st.ok = 1'b1;
                n_clear++;
            end
        endcase
        st.full  = (stored_count >= CAP);
        st.count = CW'(stored_count);
        if (st.full)
            n_full++;
        status_queue.insert(status_queue.size(), st);
    endfunction

    // Count a failure; report only the first few in detail
    function void note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $time, msg);
    endfunction

    function void add_req(input skt_op_t op, input key_t k);
        table_req_t r;
        r.op  = op;
        r.key = k;
        r.gap = calm ? 0 : $urandom_range(0, 12);
        req_queue.insert(req_queue.size(), r);
    endfunction

    // Fresh set of keys for one episode: extremes, small values and wide random ones
    function void refill_pool();
        int i;
        for (i = 0; i < POOL_SIZE; i++)
        begin
            case ($urandom_range(0, 5))
                0: key_pool[i] = KEY_MIN;
                1: key_pool[i] = KEY_MAX;
                2, 3: key_pool[i] = key_t'(int'($urandom_range(0, 6)) - 3);
                default: key_pool[i] = key_t'($urandom());
            endcase
        end
    endfunction

    // Mostly keys from the pool so that hits and duplicates are common
    function key_t pick_key();
        if ($urandom_range(0, 9) == 0)
            return key_t'($urandom());
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function skt_op_t pick_op(input logic allow_clear);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return OP_INSERT;
        if (r < 70)
            return OP_DELETE;
        if (r < 95 || !allow_clear)
            return OP_SEARCH;
        return OP_CLEAR;
    endfunction

    // Driver: present the next request at the falling edge once the last one was taken
    always @(negedge clk)
    begin
        if (rst_n && sent_count == taken_count)
        begin
            if (!have_req && req_queue.size() != 0)
            begin
                cur_req  = req_queue.pop_front();
                have_req = 1'b1;
                hold_left = cur_req.gap;
            end
            if (have_req)
            begin
                if (hold_left > 0)
                    hold_left--;
                else
                begin
                    have_req = 1'b0;
                    sent_count++;
                end
            end
        end
        if (sent_count != taken_count)
        begin
            start  <= 1'b1;
            opcode <= cur_req.op;
            key    <= cur_req.key;
        end
        else
        begin
            start  <= 1'b0;
            opcode <= 2'($urandom());
            key    <= key_t'($urandom());
        end
    end

    // Monitor: check each result, then record a request taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                n_results++;
                got = {ok, full_res, count};
                if (status_queue.size() == 0)
                    note_failure($sformatf("result with none expected: ok=%0b full=%0b count=%0d",
                                           ok, full_res, count));
                else
                begin
                    want = status_queue.pop_front();
                    if (got.ok !== want.ok || got.full !== want.full
                        || got.count !== want.count)
                        note_failure($sformatf(
                            "result %0d: expected ok=%0b full=%0b count=%0d, got ok=%0b full=%0b count=%0d",
                            n_results, want.ok, want.full, want.count,
                            got.ok, got.full, got.count));
                end
            end
            if (start && !busy)
            begin
                update_sorted_keys(skt_op_t'(opcode), key);
                taken_count++;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int episode;
        int target;

        // Directed: empty table, extremes, duplicates, misses, clear
        add_req(OP_CLEAR,  key_t'(0));
        add_req(OP_SEARCH, key_t'(0));
        add_req(OP_DELETE, key_t'(5));
        add_req(OP_INSERT, KEY_MIN);
        add_req(OP_INSERT, KEY_MAX);
        add_req(OP_INSERT, key_t'(0));
        add_req(OP_INSERT, key_t'(0));
        add_req(OP_INSERT, key_t'(-1));
        add_req(OP_INSERT, key_t'(1));
        add_req(OP_SEARCH, KEY_MIN);
        add_req(OP_SEARCH, KEY_MAX);
        add_req(OP_SEARCH, key_t'(2));
        add_req(OP_DELETE, key_t'(0));
        add_req(OP_SEARCH, key_t'(0));
        add_req(OP_DELETE, key_t'(0));
        add_req(OP_SEARCH, key_t'(0));
        add_req(OP_DELETE, key_t'(7));
        add_req(OP_DELETE, KEY_MAX);
        add_req(OP_DELETE, KEY_MIN);
        add_req(OP_INSERT, key_t'(32'h5555_5555));
        add_req(OP_INSERT, key_t'(32'hAAAA_AAAA));
        add_req(OP_CLEAR,  key_t'(0));
        add_req(OP_SEARCH, key_t'(-1));
        add_req(OP_INSERT, key_t'(-1));

        // Random episodes; the first one always fills the table past capacity
        target  = req_queue.size() + RANDOM_REQS;
        episode = 0;
        while (req_queue.size() < target)
        begin
            refill_pool();
            calm = ($urandom_range(0, 3) == 0);
            case ((episode == 0) ? 0 : $urandom_range(0, 9))
                0, 1, 2:
                begin
                    add_req(OP_CLEAR, key_t'($urandom()));
                    repeat ($urandom_range(CAP + 2, CAP + 8))
                        add_req(OP_INSERT, pick_key());
                    repeat (20)
                        add_req(pick_op(1'b0), pick_key());
                end
                8, 9:
                begin
                    repeat (20)
                        add_req(skt_op_t'($urandom_range(0, 3)), key_t'($urandom()));
                end
                default:
                begin
                    repeat (40)
                        add_req(pick_op(1'b1), pick_key());
                end
            endcase
            episode++;
        end

        // Hold reset, then release at a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain: every request taken and every result back
        while (req_queue.size() != 0 || have_req || sent_count != taken_count
               || status_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d requests: %0d inserts (%0d refused when full), %0d deletes hit,",
                 taken_count, n_insert, n_refused, n_del_hit);
        $display("%0d searches hit, %0d clears, %0d results on a full table, %0d failures.",
                 n_search_hit, n_clear, n_full, failures);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Timeout: %0d requests taken, %0d results outstanding",
                 taken_count, status_queue.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
rtl/core/skt_pkg.sv
rtl/core/skt_cell.sv
rtl/core/sorted_key_table_core.sv
tb/sv/tb_sorted_key_table_core.sv
